### rtl/tksr_pkg.sv
// shared types and constants for the slowest request tracker
package tksr_pkg;

   // store geometry
   localparam int STORE_DEPTH = 16;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int LIMIT_W     = 5;
   localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

   // field widths
   localparam int LAT_W      = 40;
   localparam int KIND_W     = 4;
   localparam int BYTES_W    = 32;
   localparam int OFFSET_W   = 48;
   localparam int RANK_W     = 5;
   localparam int REQ_DATA_W = 248;
   localparam int RSP_DATA_W = 256;

   // request operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // one kept request record
   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [BYTES_W-1:0]  request_bytes;
      logic [KIND_W-1:0]   request_kind;
      logic [LAT_W-1:0]    completion_latency;
      logic [LAT_W-1:0]    round_trip;
      logic [LAT_W-1:0]    submit_latency;
      logic [LAT_W-1:0]    total_latency;
   } rec_type;

   // per-cell control from the chain
   typedef struct packed {
      logic insert;
      logic rotate;
      logic occupied;
      logic last_occupied;
   } cell_ctl_type;

   // chain control from the sequencer
   typedef struct packed {
      logic             insert;
      logic             rotate;
      logic [CNT_W-1:0] count;
   } chain_ctl_type;

endpackage

### rtl/tksr_cell.sv
// one store cell: holds a record, inserts, shifts down or rotates up
module tksr_cell (
   input  logic                  clock,
   input  tksr_pkg::cell_ctl_type ctl,
   input  tksr_pkg::rec_type     new_rec,
   input  tksr_pkg::rec_type     prev_rec,
   input  tksr_pkg::rec_type     next_rec,
   input  tksr_pkg::rec_type     wrap_rec,
   input  logic                  prev_cond,
   output logic                  cond,
   output tksr_pkg::rec_type     rec
);

   tksr_pkg::rec_type rec_ff;
   tksr_pkg::rec_type rec_in;

   // new record belongs at or above this slot
   assign cond = !ctl.occupied || (new_rec.total_latency > rec_ff.total_latency);

   // next record for this slot
   always_comb begin
      rec_in = rec_ff;
      if (ctl.insert) begin
         if (cond && !prev_cond) begin
            rec_in = new_rec;
         end else if (cond) begin
            rec_in = prev_rec;
         end
      end else if (ctl.rotate) begin
         if (ctl.last_occupied) begin
            rec_in = wrap_rec;
         end else if (ctl.occupied) begin
            rec_in = next_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

### rtl/tksr_chain.sv
// row of store cells kept in descending latency order
module tksr_chain (
   input  logic                   clock,
   input  tksr_pkg::chain_ctl_type ctl,
   input  tksr_pkg::rec_type      new_rec,
   output tksr_pkg::rec_type      head_rec,
   output logic                   beats_tail
);

   localparam int N = tksr_pkg::STORE_DEPTH;

   tksr_pkg::rec_type      rec_q [N];
   logic [N-1:0]           cond_q;
   logic [N-1:0]           occ_q;
   tksr_pkg::cell_ctl_type cell_ctl [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_cell
         tksr_pkg::rec_type prev_r;
         tksr_pkg::rec_type next_r;
         logic              prev_c;

         // neighbor wiring, ends of the row tie to the cell itself
         if (i == 0) begin : g_first
            assign prev_r = rec_q[i];
            assign prev_c = 1'b0;
         end else begin : g_mid
            assign prev_r = rec_q[i-1];
            assign prev_c = cond_q[i-1];
         end
         if (i == N - 1) begin : g_last
            assign next_r = rec_q[i];
         end else begin : g_up
            assign next_r = rec_q[i+1];
         end

         // slot occupancy from the fill count
         assign occ_q[i] = tksr_pkg::CNT_W'(i) < ctl.count;
         assign cell_ctl[i].insert        = ctl.insert;
         assign cell_ctl[i].rotate        = ctl.rotate;
         assign cell_ctl[i].occupied      = occ_q[i];
         assign cell_ctl[i].last_occupied = tksr_pkg::CNT_W'(i + 1) == ctl.count;

         tksr_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[i]),
            .new_rec   (new_rec),
            .prev_rec  (prev_r),
            .next_rec  (next_r),
            .wrap_rec  (rec_q[0]),
            .prev_cond (prev_c),
            .cond      (cond_q[i]),
            .rec       (rec_q[i])
         );
      end
   endgenerate

   // new latency beats the smallest kept record
   assign beats_tail = |(cond_q & occ_q);
   assign head_rec   = rec_q[0];

endmodule

### rtl/top_k_slowest_request_tracker.sv
// top level: request sequencing, store chain and response register
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_tvalid/req_tready  | tdata record, tuser operation
//  rsp_    | out       | rsp_tvalid/rsp_tready  | tdata rank + record, tuser valid, tlast
//  csr_    | in        | csr_valid/csr_ready    | csr_data kept limit
//
// on a record request every cell compares and shifts in parallel.
// a report is accepted, then holds req_tready low while it sends one result per kept
// record (one when empty) as the response register frees, rotating the chain one slot per result.
// reset clears the fill count and sets the limit to 10; stored records are not cleared.
// a stall on rsp_ holds the response register and pauses the rotation.
module top_k_slowest_request_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // total, submit, round trip, completion, kind, bytes, offset, zero pad
   input  logic [tksr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rank, total, submit, round trip, completion, kind, bytes, offset, zero pad
   output logic [tksr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // entry valid
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tksr_pkg::LIMIT_W-1:0]      csr_data
);

   typedef enum logic {ST_IDLE, ST_REPORT} state_type;

   state_type                         state_ff, state_in;
   logic [tksr_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [tksr_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [tksr_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_entry_ff, rsp_entry_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [tksr_pkg::RANK_W-1:0]       rsp_rank_ff, rsp_rank_in;
   tksr_pkg::rec_type                 rsp_rec_ff, rsp_rec_in;

   tksr_pkg::rec_type                 new_rec;
   tksr_pkg::rec_type                 head_rec;
   tksr_pkg::chain_ctl_type           chain_ctl;
   logic                              beats_tail;
   logic                              req_accept;
   logic                              out_free;
   logic [tksr_pkg::CMP_W-1:0]        limit_eff;
   logic [tksr_pkg::CNT_W-1:0]        idx_next;

   // unpack request record
   assign new_rec.total_latency      = req_tdata[39:0];
   assign new_rec.submit_latency     = req_tdata[79:40];
   assign new_rec.round_trip         = req_tdata[119:80];
   assign new_rec.completion_latency = req_tdata[159:120];
   assign new_rec.request_kind       = req_tdata[163:160];
   assign new_rec.request_bytes      = req_tdata[195:164];
   assign new_rec.byte_offset        = req_tdata[243:196];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign idx_next   = idx_ff + tksr_pkg::CNT_W'(1);

   // limit clamped to the store depth
   assign limit_eff = (tksr_pkg::CMP_W'(limit_ff) > tksr_pkg::CMP_W'(tksr_pkg::STORE_DEPTH))
                      ? tksr_pkg::CMP_W'(tksr_pkg::STORE_DEPTH)
                      : tksr_pkg::CMP_W'(limit_ff);

   tksr_chain u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .new_rec    (new_rec),
      .head_rec   (head_rec),
      .beats_tail (beats_tail)
   );

   // sequencer and response register next values
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      limit_in         = limit_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_entry_in     = rsp_entry_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_rank_in      = rsp_rank_ff;
      rsp_rec_in       = rsp_rec_ff;
      chain_ctl.insert = 1'b0;
      chain_ctl.rotate = 1'b0;
      chain_ctl.count  = count_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser[0] == tksr_pkg::OP_REPORT) begin
                  state_in = ST_REPORT;
                  idx_in   = '0;
               end else if (tksr_pkg::CMP_W'(count_ff) < limit_eff) begin
                  chain_ctl.insert = 1'b1;
                  count_in         = count_ff + tksr_pkg::CNT_W'(1);
               end else if (count_ff != '0 && beats_tail) begin
                  // smallest record drops off the end, count unchanged
                  chain_ctl.insert = 1'b1;
               end
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_entry_in = 1'b0;
                  rsp_rank_in  = '0;
                  rsp_rec_in   = '0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  chain_ctl.rotate = 1'b1;
                  rsp_entry_in     = 1'b1;
                  rsp_rank_in      = tksr_pkg::RANK_W'(idx_next);
                  rsp_rec_in       = head_rec;
                  rsp_last_in      = (idx_next == count_ff);
                  idx_in           = idx_next;
                  if (idx_next == count_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         limit_ff     <= tksr_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   // pack response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tksr_pkg::RSP_DATA_W'({rsp_rec_ff, rsp_rank_ff});
   assign rsp_tuser  = rsp_entry_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
